// ===== rtl/core/bdq_pkg.sv =====
// Package for the bounded deque: operation, status, cell mode and state codes.
// Used by bdq_cell and bounded_deque_with_search_delete; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_DELETE     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  // What every cell of the row does.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_ROTATE,
    CELL_LOAD_TAIL
  } cell_mode_e;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/bdq_cell.sv =====
// One storage cell of the deque row; cell 0 holds the front entry.
// Depends on bdq_pkg for the cell mode codes.
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned INDEX = 0
) (
  input  logic                                     clk_i,
  input  bdq_pkg::cell_mode_e                      mode_i,
  input  logic [$clog2(DEPTH+1)-1:0]               len_i,
  input  logic [bdq_pkg::DATA_W-1:0]               value_i,
  input  logic [bdq_pkg::DATA_W-1:0]               prev_i,
  input  logic [bdq_pkg::DATA_W-1:0]               next_i,
  input  logic [bdq_pkg::DATA_W-1:0]               front_i,
  output logic [bdq_pkg::DATA_W-1:0]               data_o,
  output logic [bdq_pkg::DATA_W-1:0]               tail_o
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IDX    = CW'(INDEX);
  localparam logic [CW-1:0] IDX_P1 = CW'(INDEX + 1);

  logic [DATA_W-1:0] data_q, data_d;
  logic              is_tail;

  assign is_tail = (IDX_P1 == len_i);

  always_comb begin
    data_d = data_q;
    unique case (mode_i)
      CELL_SHIFT_R:   data_d = prev_i;
      CELL_SHIFT_L:   data_d = next_i;
      CELL_ROTATE: begin
        // The live part of the row turns by one; the front entry wraps to the tail.
        if (is_tail) begin
          data_d = front_i;
        end else if (IDX < len_i) begin
          data_d = next_i;
        end
      end
      CELL_LOAD_TAIL: begin
        if (IDX == len_i) begin
          data_d = value_i;
        end
      end
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tail_o = is_tail ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_deque_with_search_delete.sv =====
// Bounded deque of signed 32-bit values with search and delete by key.
// Top level: control sequencer over a row of bdq_cell; depends on bdq_pkg.
//
// A request is taken when start is high and busy is low. Pushes, pops,
// unused op codes and any request on an empty store do not set busy, and the
// result beat shows on valid_o in the following cycle. A search or a delete
// walks the live entries through cell 0 by turning the row one cell a cycle,
// so it holds busy until every entry (up to DEPTH) has passed cell 0,
// and its result beat follows the last step. The result beat lasts exactly
// one cycle and cannot be held off; a new request may be given in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search_delete #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        op_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  output logic                              valid_o,
  output logic [1:0]                        status_o,
  output logic signed [bdq_pkg::DATA_W-1:0] result_value_o
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     steps_q, steps_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic              del_q, del_d;
  logic              found_q, found_d;
  logic              valid_q, valid_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] res_q, res_d;

  cell_mode_e        mode;
  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic              walk_op;
  logic              hit;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tail [DEPTH];
  logic [DATA_W-1:0] tail_data;

  assign accept   = start && (state_q == S_IDLE);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == FULL_CNT);
  assign walk_op  = (op_i == OP_SEARCH) || (op_i == OP_DELETE);
  assign hit      = (cell_data[0] == key_q) && !found_q;

  // Row of cells: each one sees its neighbors and the front entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = value_i;
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end

    bdq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .len_i   (count_q),
      .value_i (value_i),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .front_i (cell_data[0]),
      .data_o  (cell_data[i]),
      .tail_o  (cell_tail[i])
    );
  end

  // Only the cell at the back of the live part drives a nonzero tail value.
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | cell_tail[i];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && walk_op && !is_empty) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (steps_q == ONE) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Cell control, fill count and result.
  always_comb begin
    mode     = CELL_HOLD;
    count_d  = count_q;
    steps_d  = steps_q;
    key_d    = key_q;
    del_d    = del_q;
    found_d  = found_q;
    valid_d  = 1'b0;
    status_d = status_q;
    res_d    = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d  = 1'b1;
          status_d = STS_OK;
          res_d    = '0;
          unique case (op_i)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status_d = STS_FULL;
              end else begin
                mode    = CELL_SHIFT_R;
                count_d = count_q + ONE;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                status_d = STS_FULL;
              end else begin
                mode    = CELL_LOAD_TAIL;
                count_d = count_q + ONE;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status_d = STS_EMPTY;
              end else begin
                mode    = CELL_SHIFT_L;
                res_d   = cell_data[0];
                count_d = count_q - ONE;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status_d = STS_EMPTY;
              end else begin
                res_d   = tail_data;
                count_d = count_q - ONE;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              if (is_empty) begin
                status_d = STS_EMPTY;
              end else begin
                valid_d = 1'b0;
                steps_d = count_q;
                key_d   = value_i;
                del_d   = (op_i == OP_DELETE);
                found_d = 1'b0;
              end
            end
            default: begin
              status_d = STS_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        // Entries pass cell 0 in order; after a full turn the order is restored.
        // A delete drops the first match instead of sending it to the back.
        mode = CELL_ROTATE;
        if (hit) begin
          found_d = 1'b1;
          res_d   = cell_data[0];
          if (del_q) begin
            mode    = CELL_SHIFT_L;
            count_d = count_q - ONE;
          end
        end
        steps_d = steps_q - ONE;
        if (steps_q == ONE) begin
          valid_d = 1'b1;
          if (found_q || hit) begin
            status_d = STS_OK;
          end else begin
            status_d = STS_NOT_FOUND;
            res_d    = '0;
          end
        end
      end
      default: mode = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      steps_q <= '0;
      del_q   <= 1'b0;
      found_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      steps_q <= steps_d;
      del_q   <= del_d;
      found_q <= found_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign busy           = (state_q == S_WALK);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign result_value_o = res_q;

  // A result beat only ever comes out while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result beat during a walk");

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("fill count above capacity");

  // Every request that does not walk answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !(walk_op && !is_empty)) |=> valid_o)
    else $error("single-cycle request gave no result beat");

  // A walk that ends gives its result beat right after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && steps_q == ONE) |=> (valid_o && !busy))
    else $error("walk ended without a result beat");

endmodule

`default_nettype wire
